@@ sv/rff_pkg.sv @@
// Shared types, constants and register codes of the flow and range frame filter.
package rff_pkg;

    // Frame size limits in payload bytes
    localparam logic [15:0] FLOW_MAX_BYTES  = 16'd9;
    localparam logic [15:0] RANGE_MAX_BYTES = 16'd5;

    // Q1.16 unity weight and register widths
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    localparam int ALPHA_W   = 17;
    localparam int CFG_IDX_W = 3;

    // Stream word widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 248;

    // Saturation limits of the 48-bit filtered flow values
    localparam logic signed [51:0] SAT48_HI = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] SAT48_LO = -52'sh0_8000_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM   = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_FLOW_ID  = 16'd7938;
    localparam logic [15:0] RST_RANGE_ID = 16'd7937;
    localparam logic [15:0] RST_MIN_MM   = 16'd80;
    localparam logic [15:0] RST_MAX_MM   = 16'd2000;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FLOW   = 3'd0,
        ST_RANGE  = 3'd1,
        ST_SIZE   = 3'd2,
        ST_WINDOW = 3'd3,
        ST_OTHER  = 3'd4
    } t_status;

    // Current configuration
    typedef struct packed {
        logic [16:0] alpha;
        logic [16:0] beta;
        logic [15:0] flow_id;
        logic [15:0] range_id;
        logic [15:0] min_mm;
        logic [15:0] max_mm;
    } t_cfg;

    // One input frame
    typedef struct packed {
        logic [15:0] function_id;
        logic [15:0] payload_size;
        logic [7:0]  byte_quality;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
        logic [7:0]  byte_four;
        logic [7:0]  byte_five;
        logic [7:0]  byte_six;
        logic [7:0]  byte_seven;
        logic [7:0]  byte_eight;
        logic [31:0] now_ms;
    } t_item;

    // Decoded frame with the alpha-weighted samples
    typedef struct packed {
        t_status            status;
        logic               flow_take;
        logic               range_take;
        logic               quality_nz;
        logic [31:0]        now_ms;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [49:0] ax;
        logic signed [49:0] ay;
    } t_dec;

endpackage

@@ sv/rff_config.sv @@
// Configuration registers of the flow and range frame filter.
module rff_config (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rff_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rff_pkg::ALPHA_W-1:0]   i_cfg_wdata,
    output rff_pkg::t_cfg                 o_cfg
);

    rff_pkg::t_cfg r_cfg;
    logic [16:0]   n_alpha;

    // Clamp alpha to unity
    always_comb begin
        if (i_cfg_wdata > rff_pkg::ONE_Q16) begin
            n_alpha = rff_pkg::ONE_Q16;
        end else begin
            n_alpha = i_cfg_wdata;
        end
    end

    // Decode writes, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha    <= rff_pkg::ONE_Q16;
            r_cfg.beta     <= 17'd0;
            r_cfg.flow_id  <= rff_pkg::RST_FLOW_ID;
            r_cfg.range_id <= rff_pkg::RST_RANGE_ID;
            r_cfg.min_mm   <= rff_pkg::RST_MIN_MM;
            r_cfg.max_mm   <= rff_pkg::RST_MAX_MM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rff_pkg::CFG_ALPHA: begin
                    r_cfg.alpha <= n_alpha;
                    r_cfg.beta  <= rff_pkg::ONE_Q16 - n_alpha;
                end
                rff_pkg::CFG_FLOW_ID:  r_cfg.flow_id  <= i_cfg_wdata[15:0];
                rff_pkg::CFG_RANGE_ID: r_cfg.range_id <= i_cfg_wdata[15:0];
                rff_pkg::CFG_MIN_MM:   r_cfg.min_mm   <= i_cfg_wdata[15:0];
                rff_pkg::CFG_MAX_MM:   r_cfg.max_mm   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/rff_decode.sv @@
// Frame decode: classify the frame and weight its samples by alpha.
module rff_decode (
    input  rff_pkg::t_item i_item,
    input  rff_pkg::t_cfg  i_cfg,
    output rff_pkg::t_dec  o_dec
);

    logic               flow_hit;
    logic               range_hit;
    logic               flow_big;
    logic               range_big;
    logic               in_window;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [17:0] alpha_s;
    logic signed [49:0] ax;
    logic signed [49:0] ay;

    // Assemble the little-endian words
    assign x = {i_item.byte_four, i_item.byte_three, i_item.byte_two, i_item.byte_one};
    assign y = {i_item.byte_eight, i_item.byte_seven, i_item.byte_six, i_item.byte_five};

    // Match ids, flow wins when both ids are equal
    assign flow_hit  = (i_item.function_id == i_cfg.flow_id);
    assign range_hit = !flow_hit && (i_item.function_id == i_cfg.range_id);
    assign flow_big  = (i_item.payload_size > rff_pkg::FLOW_MAX_BYTES);
    assign range_big = (i_item.payload_size > rff_pkg::RANGE_MAX_BYTES);

    // Distance window, negative values always fall outside
    assign in_window = !x[31] && (x[30:0] >= {15'd0, i_cfg.min_mm})
                       && (x[30:0] <= {15'd0, i_cfg.max_mm});

    // Weight both samples by alpha; the range lane reuses the x product
    assign alpha_s = $signed({1'b0, i_cfg.alpha});
    assign ax      = alpha_s * x;
    assign ay      = alpha_s * y;

    // Pick status and take flags
    always_comb begin
        o_dec.flow_take  = 1'b0;
        o_dec.range_take = 1'b0;
        if (flow_hit) begin
            if (flow_big) begin
                o_dec.status = rff_pkg::ST_SIZE;
            end else begin
                o_dec.status    = rff_pkg::ST_FLOW;
                o_dec.flow_take = 1'b1;
            end
        end else if (range_hit) begin
            if (range_big) begin
                o_dec.status = rff_pkg::ST_SIZE;
            end else if (in_window) begin
                o_dec.status     = rff_pkg::ST_RANGE;
                o_dec.range_take = 1'b1;
            end else begin
                o_dec.status = rff_pkg::ST_WINDOW;
            end
        end else begin
            o_dec.status = rff_pkg::ST_OTHER;
        end
        o_dec.quality_nz = (i_item.byte_quality != 8'd0);
        o_dec.now_ms     = i_item.now_ms;
        o_dec.x          = x;
        o_dec.y          = y;
        o_dec.ax         = ax;
        o_dec.ay         = ay;
    end

endmodule

@@ sv/rff_lane.sv @@
// One low-pass lane: add the (1 - alpha) share of the stored value, rounded to 2^-16.
module rff_lane (
    input  logic signed [49:0] i_ax,
    input  logic [16:0]        i_beta,
    input  logic signed [47:0] i_lpf,
    output logic signed [51:0] o_sum
);

    logic signed [31:0] hi;
    logic [15:0]        lo;
    logic signed [17:0] beta_s;
    logic signed [49:0] bh;
    logic [32:0]        bl;
    logic [33:0]        bl_rnd;

    // Split the stored value into integer and fraction parts
    assign hi     = i_lpf[47:16];
    assign lo     = i_lpf[15:0];
    assign beta_s = $signed({1'b0, i_beta});

    // Weight both parts, round the fraction part half up
    assign bh     = beta_s * hi;
    assign bl     = i_beta * lo;
    assign bl_rnd = {1'b0, bl} + 34'd32768;

    // Sum the new sample share and the old value share
    assign o_sum = 52'(i_ax) + 52'(bh) + $signed({34'd0, bl_rnd[33:16]});

endmodule

@@ sv/flow_range_frame_filter_top.sv @@
// Top level of the flow and range frame filter: handshake, filter state and result register.
// A result word becomes valid on the master side after the input, decode and result registers.
// Throughput: one word per cycle unless m_axis_tready holds the pipeline; the state update is one lane multiply stage.
// Stages: input register, decode with alpha products, lane update into result register.
// Reset (i_rst_n low at a clock edge) empties the pipeline, zeros the filter state
// and loads the configuration reset values.
module flow_range_frame_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [rff_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rff_pkg::ALPHA_W-1:0]     i_cfg_wdata,
    // Frame input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: payload_size, byte_quality, byte_one .. byte_eight, now_ms
    input  logic [rff_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: function_id
    input  logic [15:0]                     s_axis_tuser,
    // Result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: flow_x_raw, flow_y_raw, range_raw_mm, flow_x_filtered, flow_y_filtered,
    //        range_filtered, fresh_flag, last_update_ms, zero fill
    output logic [rff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [2:0]                      m_axis_tuser
);

    rff_pkg::t_cfg  cfg;
    rff_pkg::t_item r_item;
    rff_pkg::t_dec  dec;
    rff_pkg::t_dec  r_dec;

    logic r_in_vld;
    logic r_dec_vld;
    logic r_out_vld;
    logic out_free;
    logic dec_ready;
    logic in_ready;
    logic dec_adv;
    logic take;

    // Filter state
    logic signed [31:0] r_flow_x;
    logic signed [31:0] r_flow_y;
    logic [15:0]        r_range;
    logic signed [47:0] r_flow_x_lpf;
    logic signed [47:0] r_flow_y_lpf;
    logic [31:0]        r_range_lpf;
    logic               r_fresh;
    logic [31:0]        r_last;

    logic signed [31:0] n_flow_x;
    logic signed [31:0] n_flow_y;
    logic [15:0]        n_range;
    logic signed [47:0] n_flow_x_lpf;
    logic signed [47:0] n_flow_y_lpf;
    logic [31:0]        n_range_lpf;
    logic               n_fresh;
    logic [31:0]        n_last;

    logic signed [47:0] lpf0;
    logic signed [51:0] sum0;
    logic signed [51:0] sum1;
    logic signed [47:0] sat0;
    logic signed [47:0] sat1;
    logic [31:0]        clamp0;

    // Result register
    rff_pkg::t_status   r_out_status;
    logic signed [31:0] r_out_flow_x;
    logic signed [31:0] r_out_flow_y;
    logic [15:0]        r_out_range;
    logic signed [47:0] r_out_flow_x_lpf;
    logic signed [47:0] r_out_flow_y_lpf;
    logic [31:0]        r_out_range_lpf;
    logic               r_out_fresh;
    logic [31:0]        r_out_last;

    rff_config u_config (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Each stage moves when the one after it is empty or moving
    assign out_free      = !r_out_vld || m_axis_tready;
    assign dec_ready     = !r_dec_vld || out_free;
    assign in_ready      = !r_in_vld || dec_ready;
    assign dec_adv       = r_dec_vld && out_free;
    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_dec_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (dec_ready) begin
                r_dec_vld <= r_in_vld;
            end
            if (out_free) begin
                r_out_vld <= r_dec_vld;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_item.function_id  <= s_axis_tuser;
            r_item.payload_size <= s_axis_tdata[15:0];
            r_item.byte_quality <= s_axis_tdata[23:16];
            r_item.byte_one     <= s_axis_tdata[31:24];
            r_item.byte_two     <= s_axis_tdata[39:32];
            r_item.byte_three   <= s_axis_tdata[47:40];
            r_item.byte_four    <= s_axis_tdata[55:48];
            r_item.byte_five    <= s_axis_tdata[63:56];
            r_item.byte_six     <= s_axis_tdata[71:64];
            r_item.byte_seven   <= s_axis_tdata[79:72];
            r_item.byte_eight   <= s_axis_tdata[87:80];
            r_item.now_ms       <= s_axis_tdata[119:88];
        end
    end

    rff_decode u_decode (
        .i_item (r_item),
        .i_cfg  (cfg),
        .o_dec  (dec)
    );

    // Hold the decoded word and its products
    always_ff @(posedge i_clk) begin
        if (dec_ready && r_in_vld) begin
            r_dec <= dec;
        end
    end

    // Lane 0 serves flow x or the distance, lane 1 flow y
    assign lpf0 = r_dec.range_take ? $signed({16'd0, r_range_lpf}) : r_flow_x_lpf;

    rff_lane u_lane0 (
        .i_ax   (r_dec.ax),
        .i_beta (cfg.beta),
        .i_lpf  (lpf0),
        .o_sum  (sum0)
    );

    rff_lane u_lane1 (
        .i_ax   (r_dec.ay),
        .i_beta (cfg.beta),
        .i_lpf  (r_flow_y_lpf),
        .o_sum  (sum1)
    );

    // Saturate flow sums to 48 bits, clamp the distance sum to 32 bits unsigned
    always_comb begin
        if (sum0 > rff_pkg::SAT48_HI) begin
            sat0 = rff_pkg::SAT48_HI[47:0];
        end else if (sum0 < rff_pkg::SAT48_LO) begin
            sat0 = rff_pkg::SAT48_LO[47:0];
        end else begin
            sat0 = sum0[47:0];
        end
        if (sum1 > rff_pkg::SAT48_HI) begin
            sat1 = rff_pkg::SAT48_HI[47:0];
        end else if (sum1 < rff_pkg::SAT48_LO) begin
            sat1 = rff_pkg::SAT48_LO[47:0];
        end else begin
            sat1 = sum1[47:0];
        end
        if (sum0[51]) begin
            clamp0 = 32'd0;
        end else if (|sum0[50:32]) begin
            clamp0 = 32'hFFFF_FFFF;
        end else begin
            clamp0 = sum0[31:0];
        end
    end

    // Next state: update only what the frame was taken for
    assign take = r_dec.flow_take || r_dec.range_take;

    always_comb begin
        n_flow_x     = r_flow_x;
        n_flow_y     = r_flow_y;
        n_range      = r_range;
        n_flow_x_lpf = r_flow_x_lpf;
        n_flow_y_lpf = r_flow_y_lpf;
        n_range_lpf  = r_range_lpf;
        n_fresh      = r_fresh;
        n_last       = r_last;
        if (r_dec.flow_take) begin
            n_flow_x     = r_dec.x;
            n_flow_y     = r_dec.y;
            n_flow_x_lpf = sat0;
            n_flow_y_lpf = sat1;
        end
        if (r_dec.range_take) begin
            n_range     = r_dec.x[15:0];
            n_range_lpf = clamp0;
        end
        if (take) begin
            n_last  = r_dec.now_ms;
            n_fresh = r_fresh || r_dec.quality_nz;
        end
    end

    // Commit state as the word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_x     <= 32'sd0;
            r_flow_y     <= 32'sd0;
            r_range      <= 16'd0;
            r_flow_x_lpf <= 48'sd0;
            r_flow_y_lpf <= 48'sd0;
            r_range_lpf  <= 32'd0;
            r_fresh      <= 1'b0;
            r_last       <= 32'd0;
        end else if (dec_adv) begin
            r_flow_x     <= n_flow_x;
            r_flow_y     <= n_flow_y;
            r_range      <= n_range;
            r_flow_x_lpf <= n_flow_x_lpf;
            r_flow_y_lpf <= n_flow_y_lpf;
            r_range_lpf  <= n_range_lpf;
            r_fresh      <= n_fresh;
            r_last       <= n_last;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (dec_adv) begin
            r_out_status     <= r_dec.status;
            r_out_flow_x     <= n_flow_x;
            r_out_flow_y     <= n_flow_y;
            r_out_range      <= n_range;
            r_out_flow_x_lpf <= n_flow_x_lpf;
            r_out_flow_y_lpf <= n_flow_y_lpf;
            r_out_range_lpf  <= n_range_lpf;
            r_out_fresh      <= n_fresh;
            r_out_last       <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_last, r_out_fresh, r_out_range_lpf,
                            r_out_flow_y_lpf, r_out_flow_x_lpf, r_out_range,
                            r_out_flow_y, r_out_flow_x};

`ifndef SYNTHESIS
    // A rejected frame leaves the filter state untouched
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_adv && !take |=> $stable(r_flow_x_lpf) && $stable(r_flow_y_lpf)
                             && $stable(r_range_lpf) && $stable(r_last))
        else $error("state changed on a rejected frame");

    // Fresh flag only clears on reset
    a_fresh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |=> r_fresh)
        else $error("fresh flag dropped");

    // A decoded word moving on always lands in the result register
    a_dec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_adv |=> r_out_vld)
        else $error("result word lost");

    // A taken distance lies inside the window
    a_range_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_status == rff_pkg::ST_RANGE)
        |-> (r_out_range >= cfg.min_mm) && (r_out_range <= cfg.max_mm))
        else $error("taken distance outside window");

    // Flow and range are never both taken for one frame
    a_one_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec_vld |-> !(r_dec.flow_take && r_dec.range_take))
        else $error("frame taken as flow and range");
`endif

endmodule
